### src/lpp_pkg.sv
// shared types and constants of the least-probed pair picker
`default_nettype none
package lpp_pkg;

   localparam logic [1:0] CLASS_ENTRY = 2'd0;
   localparam logic [1:0] CLASS_EXIT  = 2'd1;
   localparam logic [1:0] CLASS_AUTH  = 2'd2;

   localparam logic MODE_ADD    = 1'b0;
   localparam logic MODE_CHOOSE = 1'b1;

   localparam logic CSR_PROBES_PER_RELAY   = 1'b0;
   localparam logic CSR_ONLY_MEASURE_EXITS = 1'b1;

   localparam int unsigned LEFT_W   = 14;
   localparam logic [LEFT_W:0] LEFT_MAX = 15'd16383;

   typedef struct packed {
      logic        mode;
      logic [5:0]  node_slot;
      logic        node_is_auth;
      logic        node_is_exit;
      logic [15:0] rand_target;
      logic [15:0] rand_auth;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  entry_slot;
      logic [5:0]  exit_slot;
      logic        target_was_entry;
      logic [7:0]  new_count;
      logic [13:0] probes_left;
   } rsp_type;

   typedef struct packed {
      logic add_wr;
      logic scan1;
      logic calc;
      logic scan2;
      logic upd_wr;
      logic out_req;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic fail;
      logic out_loaded;
   } status_type;

endpackage
`default_nettype wire

### src/least_probed_pair_picker_top.sv
// top level of the least-probed pair picker
//
// req channel: one item is an add (mode 0) or a choose (mode 1); taken when
// req_valid is high and req_stall low. the block works on one item at a time
// and holds req_stall high from acceptance until the result is in the output
// register, which frees the input while that result waits on rsp_stall.
// rsp channel: exactly one result per item, held while rsp_stall is high.
// csr channel: index 0 probes_per_relay, index 1 only_measure_exits; always
// ready, write only while the block is idle.
// a choose makes two passes over the slot table through its single ram read port.
// reset clears all slot valid bits at once and loads probes_per_relay 5 and
// only_measure_exits 0; no clearing pass is needed.
`default_nettype none
module least_probed_pair_picker_top #(
   parameter int unsigned SLOTS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lpp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lpp_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [7:0]       csr_wdata
);
   import lpp_pkg::*;

   logic       ppr_ff;
   logic [7:0] probes_ff;
   logic       busy, req_accept;
   cmd_type    cmd;
   status_type st;

   assign csr_ready  = 1'b1;
   assign req_stall  = busy;
   assign req_accept = req_valid & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         probes_ff <= 8'd5;
         ppr_ff    <= 1'b0;
      end else if (csr_valid & csr_ready) begin
         if (csr_index == CSR_PROBES_PER_RELAY) begin
            probes_ff <= csr_wdata;
         end else if (csr_index == CSR_ONLY_MEASURE_EXITS) begin
            ppr_ff <= csr_wdata[0];
         end
      end
   end

   lpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_mode   (req_data.mode),
      .st         (st),
      .cmd        (cmd),
      .busy       (busy)
   );

   lpp_dpath #(.SLOTS(SLOTS)) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_accept         (req_accept),
      .req_data           (req_data),
      .probes_per_relay   (probes_ff),
      .only_measure_exits (ppr_ff),
      .cmd                (cmd),
      .st                 (st),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data)
   );

   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after acceptance");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.new_count == 8'd0 &&
      rsp_data.entry_slot == 6'd0 && rsp_data.exit_slot == 6'd0)
      else $error("failed result carries a pair");

   a_choose_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ok && rsp_data.probes_left != 14'd0 |->
      rsp_data.new_count != 8'd0)
      else $error("chosen target count not incremented");

endmodule
`default_nettype wire

### src/lpp_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module lpp_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/lpp_ctrl.sv
// controller state machine of the least-probed pair picker
`default_nettype none
module lpp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire logic               req_mode,
   input  wire lpp_pkg::status_type st,
   output lpp_pkg::cmd_type        cmd,
   output logic                    busy
);
   import lpp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ADD, S_SCAN1, S_CALC, S_SCAN2, S_UPD, S_OUT
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_mode == MODE_ADD) ? S_ADD : S_SCAN1;
            end
         end
         S_ADD:   state_in = S_OUT;
         S_SCAN1: begin
            if (st.scan_done) begin
               state_in = S_CALC;
            end
         end
         S_CALC:  state_in = st.fail ? S_OUT : S_SCAN2;
         S_SCAN2: begin
            if (st.scan_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD:   state_in = S_OUT;
         S_OUT: begin
            if (st.out_loaded) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      cmd_in         = '0;
      cmd_in.add_wr  = (state_in == S_ADD);
      cmd_in.scan1   = (state_in == S_SCAN1);
      cmd_in.calc    = (state_in == S_CALC);
      cmd_in.scan2   = (state_in == S_SCAN2);
      cmd_in.upd_wr  = (state_in == S_UPD);
      cmd_in.out_req = (state_in == S_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign cmd  = cmd_ff;
   assign busy = busy_ff;
endmodule
`default_nettype wire

### src/lpp_dpath.sv
// datapath: slot table, scan accumulators, pick and result register
`default_nettype none
module lpp_dpath #(
   parameter int unsigned SLOTS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_accept,
   input  wire lpp_pkg::req_type    req_data,
   input  wire logic [7:0]          probes_per_relay,
   input  wire logic                only_measure_exits,
   input  wire lpp_pkg::cmd_type    cmd,
   output lpp_pkg::status_type      st,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lpp_pkg::rsp_type         rsp_data
);
   import lpp_pkg::*;

   localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SW:0] SLOTS_W = (SW+1)'(SLOTS);
   localparam int unsigned PW = 17 + SW;

   req_type          req_ff;
   logic [SLOTS-1:0] valid_ff;
   logic [SW:0]      addr_ff, addr_in;
   logic             p_vld_ff;
   logic             p_sv_ff;
   logic [SW-1:0]    p_idx_ff;
   logic [LEFT_W:0]  sum_ff, sum_in;
   logic [8:0]       mint_ff, mint_in, mina_ff, mina_in;
   logic [SW:0]      nt_ff, nt_in, na_ff, na_in;
   logic [SW-1:0]    kt_ff, ka_ff;
   logic [SW:0]      seent_ff, seent_in, seena_ff, seena_in;
   logic [SW-1:0]    tgt_ff, tgt_in, auth_ff, auth_in;
   logic             tentry_ff, tentry_in;
   logic             fndt_ff, fndt_in, fnda_ff, fnda_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic             issue, scanning, ram_we, out_free, out_load;
   logic [SW-1:0]    ram_waddr;
   logic [9:0]       ram_wdata, ram_rdata;
   logic [1:0]       r_cls;
   logic [7:0]       r_cnt;
   logic             is_tgt, is_auth, m_tgt, m_auth;
   logic [7:0]       need;
   logic [PW-1:0]    prod_t, prod_a;
   logic [10:0]      slot_w, tgt_w, auth_w;
   logic             add_ok;
   logic [1:0]       add_cls;
   logic [7:0]       cnt_inc;

   assign scanning = cmd.scan1 | cmd.scan2;
   assign issue    = scanning & (addr_ff < SLOTS_W);
   assign addr_in  = addr_ff + (SW+1)'(1);

   assign r_cls   = ram_rdata[9:8];
   assign r_cnt   = ram_rdata[7:0];
   assign is_tgt  = p_sv_ff & ((r_cls == CLASS_ENTRY) | (r_cls == CLASS_EXIT));
   assign is_auth = p_sv_ff & (r_cls == CLASS_AUTH);
   assign m_tgt   = is_tgt & ({1'b0, r_cnt} == mint_ff);
   assign m_auth  = is_auth & ({1'b0, r_cnt} == mina_ff);
   assign need    = (r_cnt < probes_per_relay) ? (probes_per_relay - r_cnt) : 8'd0;

   assign slot_w = 11'(req_ff.node_slot);
   assign tgt_w  = 11'(tgt_ff);
   assign auth_w = 11'(auth_ff);

   always_comb begin
      add_cls = CLASS_ENTRY;
      add_ok  = (slot_w < 11'(SLOTS));
      if (req_ff.node_is_auth) begin
         add_cls = CLASS_AUTH;
      end else if (req_ff.node_is_exit) begin
         add_cls = CLASS_EXIT;
      end else if (only_measure_exits) begin
         add_ok = 1'b0;
      end
   end

   assign cnt_inc = (mint_ff[7:0] == 8'hff) ? 8'hff : mint_ff[7:0] + 8'd1;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot_w[SW-1:0];
      ram_wdata = {add_cls, 8'd0};
      if (cmd.add_wr) begin
         ram_we = add_ok;
      end else if (cmd.upd_wr) begin
         ram_we    = 1'b1;
         ram_waddr = tgt_ff;
         ram_wdata = {(tentry_ff ? CLASS_ENTRY : CLASS_EXIT), cnt_inc};
      end
   end

   lpp_ram #(.WIDTH(10), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff[SW-1:0]),
      .rd_data (ram_rdata)
   );

   // first pass: remaining sum and least counts with their multiplicities
   always_comb begin
      sum_in  = sum_ff;
      mint_in = mint_ff;
      nt_in   = nt_ff;
      mina_in = mina_ff;
      na_in   = na_ff;
      if (cmd.scan1 & p_vld_ff) begin
         if (is_tgt) begin
            sum_in = sum_ff + (LEFT_W+1)'(need);
            if (sum_in > LEFT_MAX) begin
               sum_in = LEFT_MAX;
            end
            if ({1'b0, r_cnt} < mint_ff) begin
               mint_in = {1'b0, r_cnt};
               nt_in   = (SW+1)'(1);
            end else if ({1'b0, r_cnt} == mint_ff) begin
               nt_in = nt_ff + (SW+1)'(1);
            end
         end
         if (is_auth) begin
            if ({1'b0, r_cnt} < mina_ff) begin
               mina_in = {1'b0, r_cnt};
               na_in   = (SW+1)'(1);
            end else if ({1'b0, r_cnt} == mina_ff) begin
               na_in = na_ff + (SW+1)'(1);
            end
         end
      end
   end

   // second pass: locate the chosen candidates
   always_comb begin
      seent_in  = seent_ff;
      seena_in  = seena_ff;
      tgt_in    = tgt_ff;
      auth_in   = auth_ff;
      tentry_in = tentry_ff;
      fndt_in   = fndt_ff;
      fnda_in   = fnda_ff;
      if (cmd.scan2 & p_vld_ff) begin
         if (m_tgt & ~fndt_ff) begin
            if (seent_ff == {1'b0, kt_ff}) begin
               tgt_in    = p_idx_ff;
               tentry_in = (r_cls == CLASS_ENTRY);
               fndt_in   = 1'b1;
            end
            seent_in = seent_ff + (SW+1)'(1);
         end
         if (m_auth & ~fnda_ff) begin
            if (seena_ff == {1'b0, ka_ff}) begin
               auth_in = p_idx_ff;
               fnda_in = 1'b1;
            end
            seena_in = seena_ff + (SW+1)'(1);
         end
      end
   end

   assign prod_t = PW'(req_ff.rand_target) * PW'(nt_ff);
   assign prod_a = PW'(req_ff.rand_auth) * PW'(na_ff);

   always_comb begin
      res_in = res_ff;
      if (cmd.add_wr) begin
         res_in    = '0;
         res_in.ok = add_ok;
      end else if (cmd.calc) begin
         res_in             = '0;
         res_in.probes_left = sum_ff[LEFT_W-1:0];
      end else if (cmd.upd_wr) begin
         res_in.ok               = 1'b1;
         res_in.entry_slot       = tentry_ff ? tgt_w[5:0] : auth_w[5:0];
         res_in.exit_slot        = tentry_ff ? auth_w[5:0] : tgt_w[5:0];
         res_in.target_was_entry = tentry_ff;
         res_in.new_count        = cnt_inc;
      end
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign out_load = cmd.out_req & out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.add_wr & add_ok) begin
            valid_ff[slot_w[SW-1:0]] <= 1'b1;
         end
         p_vld_ff <= issue;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff  <= req_data;
         addr_ff <= '0;
         sum_ff  <= '0;
         mint_ff <= 9'd256;
         mina_ff <= 9'd256;
         nt_ff   <= '0;
         na_ff   <= '0;
      end else begin
         if (cmd.calc) begin
            addr_ff <= '0;
         end else if (issue) begin
            addr_ff <= addr_in;
         end
         sum_ff  <= sum_in;
         mint_ff <= mint_in;
         mina_ff <= mina_in;
         nt_ff   <= nt_in;
         na_ff   <= na_in;
      end
      if (issue) begin
         p_idx_ff <= addr_ff[SW-1:0];
         p_sv_ff  <= valid_ff[addr_ff[SW-1:0]];
      end
      if (cmd.calc) begin
         kt_ff    <= prod_t[16 +: SW];
         ka_ff    <= prod_a[16 +: SW];
         seent_ff <= '0;
         seena_ff <= '0;
         fndt_ff  <= 1'b0;
         fnda_ff  <= 1'b0;
      end else begin
         seent_ff <= seent_in;
         seena_ff <= seena_in;
         fndt_ff  <= fndt_in;
         fnda_ff  <= fnda_in;
      end
      tgt_ff    <= tgt_in;
      auth_ff   <= auth_in;
      tentry_ff <= tentry_in;
      res_ff    <= res_in;
      if (out_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign st.scan_done  = scanning & (addr_ff == SLOTS_W) & ~p_vld_ff;
   assign st.fail       = (sum_ff == '0) | (nt_ff == '0) | (na_ff == '0);
   assign st.out_loaded = out_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire
